FILE: rtl/core/ftn_pkg.sv
package ftn_pkg;

    localparam int FreqW = 32;
    localparam int LogFrac = 24;
    localparam int LogW = 5 + LogFrac;
    localparam int LogSteps = 1;
    localparam int LogStages = LogFrac / LogSteps;
    localparam int SemiW = 12;
    localparam logic [FreqW-1:0] RefReset = 32'd28835840;

    typedef logic [3:0] note_t;
    typedef logic signed [5:0] oct_t;
    typedef logic signed [9:0] detune_t;

    function automatic logic [31:0] semi_ratio(input logic [3:0] k);
        logic [31:0] r;
        begin
            case (k)
                4'd0: r = 32'd2147483648;
                4'd1: r = 32'd2275179671;
                4'd2: r = 32'd2410468894;
                4'd3: r = 32'd2553802834;
                4'd4: r = 32'd2705659852;
                4'd5: r = 32'd2866546760;
                4'd6: r = 32'd3037000500;
                4'd7: r = 32'd3217589947;
                4'd8: r = 32'd3408917802;
                4'd9: r = 32'd3611622603;
                4'd10: r = 32'd3826380858;
                4'd11: r = 32'd4053909305;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [4:0] msb_pos(input logic [31:0] x);
        logic [4:0] m;
        begin
            m = '0;
            for (int i = 0; i < 32; i++)
            begin
                if (x[i])
                begin
                    m = 5'(i);
                end
            end
            return m;
        end
    endfunction

endpackage

FILE: rtl/core/ftn_if.sv
interface ftn_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] freq_in;
    modport source (output valid, output freq_in, input ready);
    modport sink (input valid, input freq_in, output ready);
endinterface

interface ftn_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] reference_pitch;
    modport source (output valid, output reference_pitch, input ready);
    modport sink (input valid, input reference_pitch, output ready);
endinterface

interface ftn_out_if;
    logic              valid;
    logic              ready;
    logic [3:0]        note_index;
    logic signed [5:0] octave_num;
    logic signed [9:0] detune_tenths;
    logic [31:0]       tuned_freq;
    logic              sat_flag;
    logic              invalid_flag;
    modport source (output valid, output note_index, output octave_num,
                    output detune_tenths, output tuned_freq, output sat_flag,
                    output invalid_flag, input ready);
    modport sink (input valid, input note_index, input octave_num,
                  input detune_tenths, input tuned_freq, input sat_flag,
                  input invalid_flag, output ready);
endinterface

FILE: rtl/core/ftn_log_stage.sv
module ftn_log_stage
    import ftn_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [32:0] m_a,
    input  logic [32:0] m_b,
    input  logic [LogFrac-1:0] f_a,
    input  logic [LogFrac-1:0] f_b,
    output logic [32:0] m_a_reg,
    output logic [32:0] m_b_reg,
    output logic [LogFrac-1:0] f_a_reg,
    output logic [LogFrac-1:0] f_b_reg
);

    // LogSteps squaring steps on each of two mantissas; one step is a 32x32
    // square, so a single step per stage keeps every stage one multiply deep.
    function automatic logic [LogFrac+32:0] sq_steps(input logic [32:0] m0,
                                                     input logic [LogFrac-1:0] f0);
        logic [32:0] m;
        logic [LogFrac-1:0] f;
        logic [63:0] p;
        logic [32:0] t;
        begin
            m = m0;
            f = f0;
            for (int i = 0; i < LogSteps; i++)
            begin
                p = m[31:0] * m[31:0];
                t = p[63:31];
                f = {f[LogFrac-2:0], t[32]};
                m = t[32] ? {1'b0, t[32:1]} : t;
            end
            return {f, m};
        end
    endfunction

    logic [LogFrac+32:0] ra, rb;

    always_comb
    begin
        ra = sq_steps(m_a, f_a);
        rb = sq_steps(m_b, f_b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_a_reg <= ra[32:0];
            f_a_reg <= ra[LogFrac+32:33];
            m_b_reg <= rb[32:0];
            f_b_reg <= rb[LogFrac+32:33];
        end
    end

endmodule

FILE: rtl/core/frequency_to_note_top.sv
// Frequency to note converter, 12-tone equal temperament.
// Channels: in_ch carries one frequency beat (freq_in, unsigned Q16.16 Hz);
// out_ch carries one result beat per input beat, in order: note index,
// octave, detune in tenths of a cent, in-tune frequency and two flags.
// cfg_ch writes the reference pitch for A octave 3; it should only be
// written while no item is in flight.
// The pipeline has 29 register stages: normalisation, 24 log2 squaring
// stages of one squaring step each, then three arithmetic stages and the
// output register. One beat may be accepted every cycle while the
// pipeline is not stalled.
// The whole pipeline advances only when its last stage is empty or the
// receiver takes the result, so a stall freezes every stage in place and
// nothing is lost or repeated; ready to the sender follows that condition.
// Reset clears all stage valid bits and loads the reference pitch with
// 440 Hz; payload registers are not reset.
module frequency_to_note_top
    import ftn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ftn_in_if.sink    in_ch,
    ftn_cfg_if.sink   cfg_ch,
    ftn_out_if.source out_ch
);

    localparam int Nv = LogStages + 5;

    logic [31:0] ref_reg;
    logic [Nv-1:0] v_reg;
    logic adv;

    assign adv = !v_reg[Nv-1] || out_ch.ready;
    assign in_ch.ready = adv;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= RefReset;
            v_reg <= '0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                ref_reg <= cfg_ch.reference_pitch;
            end
            if (adv)
            begin
                v_reg <= {v_reg[Nv-2:0], in_ch.valid};
            end
        end
    end

    // Stage 0: normalise both mantissas.
    logic [32:0] m0a_reg, m0b_reg;
    logic [4:0] e0a_reg, e0b_reg;
    logic inv0_reg;
    logic [31:0] ref0_reg;
    logic [4:0] ea, eb;

    always_comb
    begin
        ea = msb_pos(in_ch.freq_in);
        eb = msb_pos(ref_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m0a_reg <= {1'b0, in_ch.freq_in << (5'd31 - ea)};
            m0b_reg <= {1'b0, ref_reg << (5'd31 - eb)};
            e0a_reg <= ea;
            e0b_reg <= eb;
            inv0_reg <= (in_ch.freq_in == '0) || (ref_reg == '0);
            ref0_reg <= ref_reg;
        end
    end

    // Squaring stages with side data delayed alongside.
    logic [32:0] ma [LogStages+1];
    logic [32:0] mb [LogStages+1];
    logic [LogFrac-1:0] fa [LogStages+1];
    logic [LogFrac-1:0] fb [LogStages+1];
    logic [4:0] ea_d_reg [LogStages+1];
    logic [4:0] eb_d_reg [LogStages+1];
    logic inv_d_reg [LogStages+1];
    logic [31:0] ref_d_reg [LogStages+1];

    assign ma[0] = m0a_reg;
    assign mb[0] = m0b_reg;
    assign fa[0] = '0;
    assign fb[0] = '0;

    always_comb
    begin
        ea_d_reg[0] = e0a_reg;
        eb_d_reg[0] = e0b_reg;
        inv_d_reg[0] = inv0_reg;
        ref_d_reg[0] = ref0_reg;
    end

    for (genvar g = 0; g < LogStages; g++)
    begin : g_log
        ftn_log_stage u_stage (
            .clk (clk), .en (adv),
            .m_a (ma[g]), .m_b (mb[g]), .f_a (fa[g]), .f_b (fb[g]),
            .m_a_reg (ma[g+1]), .m_b_reg (mb[g+1]),
            .f_a_reg (fa[g+1]), .f_b_reg (fb[g+1])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ea_d_reg[g+1] <= ea_d_reg[g];
                eb_d_reg[g+1] <= eb_d_reg[g];
                inv_d_reg[g+1] <= inv_d_reg[g];
                ref_d_reg[g+1] <= ref_d_reg[g];
            end
        end
    end

    // Stage A: b = 12*(la - lb) + 1/2 + 1200, always positive.
    localparam int BW = 12 + LogFrac;
    logic [BW-1:0] b_reg;
    logic invA_reg;
    logic [31:0] refA_reg;
    logic signed [LogW+1:0] dl;
    logic signed [LogW+5:0] s12;

    always_comb
    begin
        dl = $signed({2'b0, ea_d_reg[LogStages], fa[LogStages]})
           - $signed({2'b0, eb_d_reg[LogStages], fb[LogStages]});
        s12 = (LogW+6)'(dl) * $signed((LogW+6)'(12));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg <= BW'(s12) + (BW'(1) << (LogFrac-1)) + (BW'(1200) << LogFrac);
            invA_reg <= inv_d_reg[LogStages];
            refA_reg <= ref_d_reg[LogStages];
        end
    end

    // Stage B: split semitones by 12 (reciprocal), detune tenths.
    logic [SemiW-1:0] semi;
    logic [LogFrac-1:0] frac;
    logic [SemiW-1:0] qd, rm;
    logic [SemiW+11:0] qm;
    logic [LogFrac+10:0] tprod;
    logic [9:0] tenths;
    logic [3:0] kB_reg;
    logic [7:0] qB_reg;
    logic [SemiW-1:0] semiB_reg;
    logic [9:0] tenB_reg;
    logic invB_reg;
    logic [31:0] refB_reg;

    always_comb
    begin
        semi = b_reg[BW-1:LogFrac];
        frac = b_reg[LogFrac-1:0];
        qm = semi * 12'd2731;
        qd = SemiW'(qm >> 15);
        rm = semi - 12'(qd * 12'd12);
        if (rm >= 12'd12)
        begin
            qd = qd + 12'd1;
            rm = rm - 12'd12;
        end
        tprod = (LogFrac+11)'(frac) * (LogFrac+11)'(1000)
              + ((LogFrac+11)'(1) << (LogFrac-1));
        tenths = 10'(tprod >> LogFrac);
        if (tprod[LogFrac+10:LogFrac] > 11'd999)
        begin
            tenths = 10'd999;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kB_reg <= rm[3:0];
            qB_reg <= qd[7:0];
            semiB_reg <= semi;
            tenB_reg <= tenths;
            invB_reg <= invA_reg;
            refB_reg <= refA_reg;
        end
    end

    // Stage C: product ref * ratio, octave.
    logic [63:0] prodC_reg;
    logic [3:0] kC_reg;
    logic [7:0] qC_reg;
    logic signed [5:0] octC_reg;
    logic [9:0] tenC_reg;
    logic invC_reg;
    logic signed [13:0] oc;
    logic [SemiW-1:0] s3, o3;
    logic [SemiW+11:0] om;

    always_comb
    begin
        s3 = semiB_reg - 12'd3;
        om = s3 * 12'd2731;
        o3 = SemiW'(om >> 15);
        if (s3 - 12'(o3 * 12'd12) >= 12'd12)
        begin
            o3 = o3 + 12'd1;
        end
        oc = $signed({2'b0, o3}) - 14'sd96;
        if (semiB_reg < 12'd3)
        begin
            oc = -14'sd96;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prodC_reg <= refB_reg * semi_ratio(kB_reg);
            kC_reg <= kB_reg;
            qC_reg <= qB_reg;
            octC_reg <= (oc > 14'sd31) ? 6'sd31 : (oc < -14'sd32) ? -6'sd32 : 6'(oc);
            tenC_reg <= tenB_reg;
            invC_reg <= invB_reg;
        end
    end

    // Stage D: scale by 2^q with rounding and saturation.
    logic signed [9:0] sh;
    logic [64:0] tt;
    logic [64:0] tr;
    logic [31:0] tuned;
    logic sat;

    always_comb
    begin
        sh = 10'sd131 - $signed({2'b0, qC_reg});
        tuned = '0;
        sat = 1'b0;
        tt = '0;
        tr = '0;
        if (sh < 0)
        begin
            sat = 1'b1;
        end
        else if (sh == 0)
        begin
            sat = |prodC_reg[63:32];
            tuned = prodC_reg[31:0];
        end
        else if (sh <= 10'sd64)
        begin
            tt = {1'b0, prodC_reg} >> (sh - 10'sd1);
            tr = (tt >> 1) + {64'b0, tt[0]};
            sat = |tr[64:32];
            tuned = tr[31:0];
        end
        if (sat)
        begin
            tuned = '1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_ch.note_index <= invC_reg ? 4'd0 : kC_reg;
            out_ch.octave_num <= invC_reg ? 6'sd0 : octC_reg;
            out_ch.detune_tenths <= invC_reg ? 10'sd0 : $signed(tenC_reg - 10'd500);
            out_ch.tuned_freq <= invC_reg ? 32'd0 : tuned;
            out_ch.sat_flag <= invC_reg ? 1'b0 : sat;
            out_ch.invalid_flag <= invC_reg;
        end
    end

    assign out_ch.valid = v_reg[Nv-1];

endmodule
